// ===== rtl/core/joystick_axis_qualifier_defines.svh =====
// assertion macros shared by the joystick axis qualifier rtl
`ifndef JOYSTICK_AXIS_QUALIFIER_DEFINES_SVH
`define JOYSTICK_AXIS_QUALIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define JAQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define JAQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/jaq_pkg.sv =====
// types, codes and constants of the joystick axis qualifier
`timescale 1ns / 1ps

package jaq_pkg;

    // converter reading width
    localparam int SAMPLE_BITS = 12;

    localparam int CMD_W       = 2;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 8;
    localparam int MAG_W       = 7;
    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 16;
    localparam int COUNT_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POLL   = 2'd2;

    // poll modes
    localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HOLD       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ONE_SHOT   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_VALID    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WITHHELD = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_REPEAT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE       = 3'd6;

    // register reset values
    localparam logic [MAG_W-1:0]      DEAD_ZONE_RST    = 7'd5;
    localparam logic [MAG_W-1:0]      PRESS_RST        = 7'd15;
    localparam logic [MAG_W-1:0]      RELEASE_RST      = 7'd7;
    localparam logic [INTERVAL_W-1:0] HOLD_RST         = 16'd500;
    localparam logic [INTERVAL_W-1:0] FIRST_REPEAT_RST = 16'd1000;
    localparam logic [INTERVAL_W-1:0] REPEAT_RST       = 16'd100;
    localparam logic [COUNT_W-1:0]    SETTLE_RST       = 8'd7;

    // position arithmetic
    localparam logic [POS_W-1:0] POS_OFFSET  = 8'd127;
    localparam logic [POS_W-1:0] POS_MAX     = 8'd127;
    localparam logic [POS_W-1:0] TOP_FULL    = 8'hFF;
    localparam logic [POS_W-1:0] POS_INVALID = 8'h80;
    localparam logic [POS_W-1:0] DIR_PLUS    = 8'h01;
    localparam logic [POS_W-1:0] DIR_MINUS   = 8'hFF;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [SAMPLE_BITS-1:0] adc_sample;
        logic [MODE_W-1:0]      mode;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [POS_W-1:0] value;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t result;
    } step_out_t;

    typedef struct packed {
        logic [MAG_W-1:0]      dead_zone;
        logic [MAG_W-1:0]      press_threshold;
        logic [MAG_W-1:0]      release_threshold;
        logic [INTERVAL_W-1:0] hold_interval;
        logic [INTERVAL_W-1:0] first_repeat_delay;
        logic [INTERVAL_W-1:0] repeat_interval;
        logic [COUNT_W-1:0]    settle_count;
    } cfg_t;

endpackage

// ===== rtl/core/jaq_ifs.sv =====
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface jaq_item_if;
    import jaq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic [MODE_W-1:0]      mode;

    modport source (output valid, output command, output adc_sample, output mode,
                    input ready);
    modport sink   (input valid, input command, input adc_sample, input mode,
                    output ready);
endinterface

interface jaq_result_if;
    import jaq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [POS_W-1:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

// ===== rtl/core/jaq_cfg_regs.sv =====
// configuration register file of the joystick axis qualifier
`timescale 1ns / 1ps

module jaq_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [jaq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [jaq_pkg::CFG_DATA_W-1:0]   cfg_data,
    output jaq_pkg::cfg_t                    cfg
);
    import jaq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEAD_ZONE:    cfg_next.dead_zone          = cfg_data[MAG_W-1:0];
                REG_PRESS:        cfg_next.press_threshold    = cfg_data[MAG_W-1:0];
                REG_RELEASE:      cfg_next.release_threshold  = cfg_data[MAG_W-1:0];
                REG_HOLD:         cfg_next.hold_interval      = cfg_data[INTERVAL_W-1:0];
                REG_FIRST_REPEAT: cfg_next.first_repeat_delay = cfg_data[INTERVAL_W-1:0];
                REG_REPEAT:       cfg_next.repeat_interval    = cfg_data[INTERVAL_W-1:0];
                REG_SETTLE:       cfg_next.settle_count       = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_zone          <= DEAD_ZONE_RST;
            cfg_reg.press_threshold    <= PRESS_RST;
            cfg_reg.release_threshold  <= RELEASE_RST;
            cfg_reg.hold_interval      <= HOLD_RST;
            cfg_reg.first_repeat_delay <= FIRST_REPEAT_RST;
            cfg_reg.repeat_interval    <= REPEAT_RST;
            cfg_reg.settle_count       <= SETTLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/jaq_axis_core.sv =====
// axis state and single-pass qualification of one word
`timescale 1ns / 1ps
`include "joystick_axis_qualifier_defines.svh"

module jaq_axis_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  jaq_pkg::item_t     item_in,
    input  jaq_pkg::cfg_t      cfg,
    output jaq_pkg::step_out_t step_out
);
    import jaq_pkg::*;

    logic signed [POS_W-1:0] settled_reg, settled_next;
    logic [COUNT_W-1:0]      diff_reg, diff_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [TIME_W-1:0]       mark_reg, mark_next;
    logic signed [POS_W-1:0] last_reg, last_next;
    logic                    latched_reg, latched_next;
    logic                    repeating_reg, repeating_next;

    logic [POS_W-1:0]        top_byte;
    logic [POS_W-1:0]        reading;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [POS_W-1:0]        offset_val;
    logic [POS_W-1:0]        dir;
    logic [TIME_W-1:0]       elapsed;
    logic                    hold_pass;
    logic                    first_pass;
    logic                    repeat_pass;
    logic                    rep_hit;
    logic                    first_hit;
    logic                    pressed;
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        val;

    // reading: top byte minus offset, full scale saturates
    assign top_byte = item_in.adc_sample[SAMPLE_BITS-1 -: POS_W];
    assign reading  = (top_byte == TOP_FULL) ? POS_MAX : POS_W'(top_byte - POS_OFFSET);

    // magnitude, direction and dead-zone offset of the settled position
    assign neg        = settled_reg[POS_W-1];
    assign mag        = neg ? MAG_W'(-settled_reg) : settled_reg[MAG_W-1:0];
    assign dir        = neg ? DIR_MINUS : DIR_PLUS;
    assign offset_val = neg ? POS_W'(settled_reg + {1'b0, cfg.dead_zone})
                            : POS_W'(settled_reg - {1'b0, cfg.dead_zone});
    assign pressed    = (mag > cfg.press_threshold);

    // interval checks against the shared mark
    assign elapsed     = time_reg - mark_reg;
    assign hold_pass   = (elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.hold_interval});
    assign first_pass  = (elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.first_repeat_delay});
    assign repeat_pass = (elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.repeat_interval});
    // after a repeat the mark is fresh, so the first-delay check needs a zero delay
    assign rep_hit     = repeating_reg && repeat_pass;
    assign first_hit   = rep_hit ? (cfg.first_repeat_delay == '0) : first_pass;

    // next state and result of the word
    always_comb
    begin
        settled_next   = settled_reg;
        diff_next      = diff_reg;
        time_next      = time_reg;
        mark_next      = mark_reg;
        last_next      = last_reg;
        latched_next   = latched_reg;
        repeating_next = repeating_reg;
        status         = STATUS_NONE;
        val            = '0;
        if (step)
        begin
            unique case (item_in.command)
                CMD_SAMPLE:
                begin
                    diff_next = (reading == settled_reg) ? '0 : COUNT_W'(diff_reg + 1'b1);
                    if (diff_next > cfg.settle_count)
                    begin
                        settled_next = reading;
                    end
                end
                CMD_TICK:
                begin
                    time_next = TIME_W'(time_reg + 1'b1);
                end
                CMD_POLL:
                begin
                    unique case (item_in.mode)
                        MODE_CONTINUOUS:
                        begin
                            if (mag > cfg.dead_zone)
                            begin
                                val    = offset_val;
                                status = STATUS_VALID;
                            end
                        end
                        MODE_HOLD:
                        begin
                            if (mag > cfg.dead_zone)
                            begin
                                if (offset_val == last_reg)
                                begin
                                    if (hold_pass)
                                    begin
                                        mark_next = time_reg;
                                        val       = last_reg;
                                        status    = STATUS_VALID;
                                    end
                                    else
                                    begin
                                        status = STATUS_WITHHELD;
                                    end
                                end
                                else
                                begin
                                    val       = offset_val;
                                    last_next = offset_val;
                                    status    = STATUS_VALID;
                                end
                            end
                        end
                        MODE_AUTO:
                        begin
                            if (pressed)
                            begin
                                if (!latched_reg)
                                begin
                                    latched_next = 1'b1;
                                    mark_next    = time_reg;
                                    status       = STATUS_VALID;
                                    val          = dir;
                                end
                                else if (rep_hit || first_hit)
                                begin
                                    mark_next = time_reg;
                                    status    = STATUS_VALID;
                                    val       = dir;
                                    if (first_hit)
                                    begin
                                        repeating_next = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                repeating_next = 1'b0;
                                if (mag < cfg.release_threshold)
                                begin
                                    latched_next = 1'b0;
                                end
                            end
                        end
                        MODE_ONE_SHOT:
                        begin
                            if (pressed)
                            begin
                                if (!latched_reg)
                                begin
                                    latched_next = 1'b1;
                                    val          = dir;
                                    status       = STATUS_VALID;
                                end
                            end
                            else if (mag < cfg.release_threshold)
                            begin
                                latched_next = 1'b0;
                            end
                        end
                    endcase
                end
                default:
                begin
                    status = STATUS_NONE;
                end
            endcase
        end
    end

    // axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg   <= '0;
            diff_reg      <= '0;
            time_reg      <= '0;
            mark_reg      <= '0;
            last_reg      <= '0;
            latched_reg   <= 1'b0;
            repeating_reg <= 1'b0;
        end
        else
        begin
            settled_reg   <= settled_next;
            diff_reg      <= diff_next;
            time_reg      <= time_next;
            mark_reg      <= mark_next;
            last_reg      <= last_next;
            latched_reg   <= latched_next;
            repeating_reg <= repeating_next;
        end
    end

    assign step_out.valid         = (status != STATUS_NONE);
    assign step_out.result.status = status;
    assign step_out.result.value  = val;

    // checks
    `JAQ_ASSERT_IMPL(a_pos_range, 1'b1, settled_reg != POS_INVALID, "settled position out of range")
    `JAQ_ASSERT_IMPL(a_poll_only, step_out.valid, step && item_in.command == CMD_POLL, "result from non-poll word")
    `JAQ_ASSERT_IMPL(a_withheld_zero, step_out.result.status == STATUS_WITHHELD, step_out.result.value == '0, "withheld value not zero")
    `JAQ_ASSERT_NEXT(a_tick_adv, step && item_in.command == CMD_TICK, time_reg == 32'($past(time_reg) + 32'd1), "tick did not advance time")

endmodule

// ===== rtl/core/joystick_axis_qualifier.sv =====
// top level of the joystick axis qualifier: input stage, axis core, result register
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    command, adc_sample, mode
//  result   out  valid/ready    status, value
//  cfg      in   cfg_we         cfg_index, cfg_data
//
// one word per cycle while the result register is free; a taken word is held in the input stage until processed
// a poll result is written to the result register as it is processed
// the input stage refills in the cycle a stalled result is taken (ready path from result.ready)
// rst_n clears the axis state, the valid flags and restores register defaults
`timescale 1ns / 1ps
`include "joystick_axis_qualifier_defines.svh"

module joystick_axis_qualifier (
    input  logic                            clk,
    input  logic                            rst_n,
    jaq_item_if.sink                        item,
    jaq_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [jaq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [jaq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jaq_pkg::*;

    cfg_t      cfg;
    item_t     item_reg;
    logic      item_valid_reg, item_valid_next;
    result_t   result_reg;
    logic      out_valid_reg, out_valid_next;
    step_out_t step_out;
    logic      out_free;
    logic      s1_fire;
    logic      in_accept;

    jaq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jaq_axis_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_fire),
        .item_in  (item_reg),
        .cfg      (cfg),
        .step_out (step_out)
    );

    // flow control
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_fire    = item_valid_reg && out_free;
    assign item.ready = !item_valid_reg || s1_fire;
    assign in_accept  = item.valid && item.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item.ready)
        begin
            item_valid_next = item.valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_fire && step_out.valid;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.command    <= item.command;
            item_reg.adc_sample <= item.adc_sample;
            item_reg.mode       <= item.mode;
        end
        if (s1_fire && step_out.valid)
        begin
            result_reg <= step_out.result;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.status = result_reg.status;
    assign result.value  = result_reg.value;

    // checks
    `JAQ_ASSERT_NEXT(a_result_loaded, s1_fire && step_out.valid, out_valid_reg, "result word lost")
    `JAQ_ASSERT_NEXT(a_held_word, item_valid_reg && !s1_fire, item_valid_reg, "pending word dropped")

endmodule

// ===== test/joystick_axis_qualifier_checker.sv =====
// checker for the joystick axis qualifier: predicts result words and compares them
`timescale 1ns / 1ps

module joystick_axis_qualifier_checker
    import jaq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    jaq_item_if                    item,
    jaq_result_if                  result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            owed,
    output int unsigned            failures,
    output int unsigned            compared
);

    // shadow registers and axis state
    cfg_t                    regs;
    logic signed [POS_W-1:0] settled_pos;
    logic [COUNT_W-1:0]      diff_run;
    logic [TIME_W-1:0]       ms_now;
    logic [TIME_W-1:0]       mark;
    logic signed [POS_W-1:0] last_value;
    logic                    latched;
    logic                    auto_on;

    result_t     owed_results[$];
    result_t     want;
    int unsigned miss_count;
    int unsigned match_count;

    // interval test shared by hold and auto-repeat; restarts the mark when it passes
    function automatic bit span_elapsed(input logic [INTERVAL_W-1:0] span);
        logic [TIME_W-1:0] gap;
        gap = ms_now - mark;
        if (gap >= TIME_W'(span))
        begin
            mark = ms_now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the axis by one input word and queue the result word it owes
    task automatic step_axis(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_BITS-1:0] adc,
                             input logic [MODE_W-1:0] md);
        int                  pos;
        int                  mag;
        int                  reading;
        int                  shown;
        int                  nv;
        int                  dz;
        int                  press;
        int                  rel;
        logic [STATUS_W-1:0] st;
        result_t             r;
        pos   = int'(settled_pos);
        mag   = (pos < 0) ? -pos : pos;
        dz    = int'(regs.dead_zone);
        press = int'(regs.press_threshold);
        rel   = int'(regs.release_threshold);
        st    = STATUS_NONE;
        shown = 0;
        case (cmd)
            CMD_SAMPLE:
            begin
                // top byte minus offset, top value saturates
                reading = int'(adc[SAMPLE_BITS-1 -: 8]) - int'(POS_OFFSET);
                if (reading > int'(POS_MAX))
                    reading = int'(POS_MAX);
                if (reading == pos)
                    diff_run = '0;
                else
                    diff_run = diff_run + 1'b1;
                if (diff_run > regs.settle_count)
                    settled_pos = reading[POS_W-1:0];
            end
            CMD_TICK:
                ms_now = ms_now + 1'b1;
            CMD_POLL:
            begin
                case (md)
                    MODE_CONTINUOUS:
                    begin
                        if (mag > dz)
                        begin
                            shown = (pos > 0) ? pos - dz : pos + dz;
                            st    = STATUS_VALID;
                        end
                    end
                    MODE_HOLD:
                    begin
                        if (mag > dz)
                        begin
                            nv = (pos > 0) ? pos - dz : pos + dz;
                            if (nv == int'(last_value))
                            begin
                                if (span_elapsed(regs.hold_interval))
                                begin
                                    shown = int'(last_value);
                                    st    = STATUS_VALID;
                                end
                                else
                                begin
                                    st = STATUS_WITHHELD;
                                end
                            end
                            else
                            begin
                                shown      = nv;
                                last_value = nv[POS_W-1:0];
                                st         = STATUS_VALID;
                            end
                        end
                    end
                    MODE_AUTO:
                    begin
                        if (mag > press)
                        begin
                            if (!latched)
                            begin
                                latched = 1'b1;
                                mark    = ms_now;
                                st      = STATUS_VALID;
                            end
                            else
                            begin
                                // repeat check first, then first-delay check on the same mark
                                if (auto_on)
                                begin
                                    if (span_elapsed(regs.repeat_interval))
                                        st = STATUS_VALID;
                                end
                                if (span_elapsed(regs.first_repeat_delay))
                                begin
                                    auto_on = 1'b1;
                                    st      = STATUS_VALID;
                                end
                            end
                            if (st == STATUS_VALID)
                                shown = (pos > 0) ? 1 : -1;
                        end
                        else
                        begin
                            auto_on = 1'b0;
                            if (mag < rel)
                                latched = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (mag > press)
                        begin
                            if (!latched)
                            begin
                                latched = 1'b1;
                                shown   = (pos > 0) ? 1 : -1;
                                st      = STATUS_VALID;
                            end
                        end
                        else if (mag < rel)
                        begin
                            latched = 1'b0;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        if (st != STATUS_NONE)
        begin
            r.status = st;
            r.value  = (st == STATUS_WITHHELD) ? '0 : shown[POS_W-1:0];
            owed_results.push_back(r);
        end
    endtask

    // compare taken result words, track register writes, predict taken input words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs        = '{DEAD_ZONE_RST, PRESS_RST, RELEASE_RST, HOLD_RST,
                            FIRST_REPEAT_RST, REPEAT_RST, SETTLE_RST};
            settled_pos = '0;
            diff_run    = '0;
            ms_now      = '0;
            mark        = '0;
            last_value  = '0;
            latched     = 1'b0;
            auto_on     = 1'b0;
            miss_count  = 0;
            match_count = 0;
            owed_results.delete();
            owed     <= 0;
            failures <= 0;
            compared <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d value %0d",
                           result.status, $signed(result.value));
                    miss_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    match_count++;
                    if (result.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, result.status);
                        miss_count++;
                    end
                    if (result.value !== want.value)
                    begin
                        $error("value mismatch: expected %0d, actual %0d",
                               $signed(want.value), $signed(result.value));
                        miss_count++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEAD_ZONE:    regs.dead_zone          = cfg_data[MAG_W-1:0];
                    REG_PRESS:        regs.press_threshold    = cfg_data[MAG_W-1:0];
                    REG_RELEASE:      regs.release_threshold  = cfg_data[MAG_W-1:0];
                    REG_HOLD:         regs.hold_interval      = cfg_data[INTERVAL_W-1:0];
                    REG_FIRST_REPEAT: regs.first_repeat_delay = cfg_data[INTERVAL_W-1:0];
                    REG_REPEAT:       regs.repeat_interval    = cfg_data[INTERVAL_W-1:0];
                    REG_SETTLE:       regs.settle_count       = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (item.valid && item.ready)
                step_axis(item.command, item.adc_sample, item.mode);

            owed     <= owed_results.size();
            failures <= miss_count;
            compared <= match_count;
        end
    end

endmodule

// ===== test/joystick_axis_qualifier_test.sv =====
// top of the joystick axis qualifier testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module joystick_axis_qualifier_test;
    import jaq_pkg::*;

    // command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CHOKE_CYCLES = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int unsigned owed;
    int unsigned failures;
    int unsigned compared;
    int unsigned send_gap_pct;
    int unsigned take_gap_pct;
    int unsigned words_sent;
    int unsigned settings_used;
    logic        choke_go;
    logic        choking;
    logic [7:0]  aim;

    jaq_item_if   item ();
    jaq_result_if result ();

    joystick_axis_qualifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    joystick_axis_qualifier_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .owed      (owed),
        .failures  (failures),
        .compared  (compared)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls, held low while choking
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= rst_n && !choking && ($urandom_range(99) >= take_gap_pct);
        end
    end

    // long receiver hold-off, counted here once requested
    initial
    begin
        choking = 1'b0;
        wait (choke_go === 1'b1);
        @(posedge clk);
        choking <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choking <= 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // offer one input word, with random idle cycles ahead of it
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_BITS-1:0] adc,
                         input logic [MODE_W-1:0] md);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid      <= 1'b1;
        item.command    <= cmd;
        item.adc_sample <= adc;
        item.mode       <= md;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // random word of any command; its samples mostly near a drifting target so the debounce settles
    task automatic offer_random();
        logic [CMD_W-1:0]       cmd;
        logic [SAMPLE_BITS-1:0] adc;
        logic [MODE_W-1:0]      md;
        int unsigned            pick;
        adc  = SAMPLE_BITS'($urandom);
        md   = MODE_W'($urandom);
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0)
            aim = $urandom_range(1) ? 8'($urandom) : 8'(107 + $urandom_range(40));
        if (pick < 45)
        begin
            cmd = CMD_SAMPLE;
            if ($urandom_range(9) < 8)
                adc[SAMPLE_BITS-1 -: 8] = aim;
        end
        else if (pick < 67)
            cmd = CMD_TICK;
        else if (pick < 96)
            cmd = CMD_POLL;
        else
            cmd = CMD_UNUSED;
        offer(cmd, adc, md);
    endtask

    // stop offering, wait until every owed word is back and the pipe is empty
    task automatic quiesce();
        item.valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // load a full register set while the block is idle
    task automatic apply_settings(input cfg_t s);
        quiesce();
        write_reg(REG_DEAD_ZONE, CFG_DATA_W'(s.dead_zone));
        write_reg(REG_PRESS, CFG_DATA_W'(s.press_threshold));
        write_reg(REG_RELEASE, CFG_DATA_W'(s.release_threshold));
        write_reg(REG_HOLD, s.hold_interval);
        write_reg(REG_FIRST_REPEAT, s.first_repeat_delay);
        write_reg(REG_REPEAT, s.repeat_interval);
        write_reg(REG_SETTLE, CFG_DATA_W'(s.settle_count));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // stimulus
    initial
    begin
        rst_n           = 1'b0;
        item.valid      = 1'b0;
        item.command    = CMD_SAMPLE;
        item.adc_sample = '0;
        item.mode       = MODE_CONTINUOUS;
        cfg_we          = 1'b0;
        cfg_index       = REG_DEAD_ZONE;
        cfg_data        = '0;
        choke_go        = 1'b0;
        send_gap_pct    = 14;
        take_gap_pct    = 60;
        words_sent      = 0;
        settings_used   = 0;
        aim             = 8'd127;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short intervals, immediate replacement
        apply_settings(cfg_t'{7'd5, 7'd15, 7'd7, 16'd2, 16'd3, 16'd1, 8'd0});
        offer(CMD_SAMPLE, 12'hFFF, MODE_CONTINUOUS);   // saturates to full positive
        offer(CMD_POLL, 12'h000, MODE_CONTINUOUS);
        offer(CMD_POLL, 12'h000, MODE_HOLD);           // new value
        offer(CMD_POLL, 12'h000, MODE_HOLD);           // unchanged, withheld
        offer(CMD_TICK, 12'h000, MODE_CONTINUOUS);
        offer(CMD_TICK, 12'h000, MODE_CONTINUOUS);
        offer(CMD_POLL, 12'h000, MODE_HOLD);           // hold interval passed
        offer(CMD_POLL, 12'h000, MODE_AUTO);           // press
        offer(CMD_POLL, 12'h000, MODE_AUTO);           // nothing yet
        offer(CMD_TICK, 12'h000, MODE_CONTINUOUS);
        offer(CMD_TICK, 12'h000, MODE_CONTINUOUS);
        offer(CMD_TICK, 12'h000, MODE_CONTINUOUS);
        offer(CMD_POLL, 12'h000, MODE_AUTO);           // first repeat
        offer(CMD_TICK, 12'h000, MODE_CONTINUOUS);
        offer(CMD_POLL, 12'h000, MODE_AUTO);           // steady repeat
        offer(CMD_UNUSED, 12'hABC, MODE_HOLD);         // ignored
        offer(CMD_SAMPLE, 12'h7F0, MODE_ONE_SHOT);     // center
        offer(CMD_POLL, 12'hFFF, MODE_ONE_SHOT);       // release
        offer(CMD_SAMPLE, 12'h000, MODE_AUTO);         // full negative
        offer(CMD_POLL, 12'h000, MODE_ONE_SHOT);       // one shot
        offer(CMD_POLL, 12'h000, MODE_ONE_SHOT);       // still latched, nothing
        offer(CMD_POLL, 12'h000, MODE_CONTINUOUS);
        offer(CMD_SAMPLE, 12'h800, MODE_CONTINUOUS);   // just off center
        offer(CMD_POLL, 12'h000, MODE_CONTINUOUS);     // inside dead zone

        // sender light, receiver heavy
        apply_settings(cfg_t'{7'd5, 7'd15, 7'd7, 16'd20, 16'd30, 16'd8, 8'd3});
        repeat (150) offer_random();
        apply_settings(cfg_t'{7'd127, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255});
        repeat (40) offer_random();

        // long runs of differing readings wrap the difference count
        apply_settings(cfg_t'{7'd0, 7'd60, 7'd30, 16'd3, 16'd6, 16'd2, 8'd200});
        for (int i = 0; i < 300; i++)
        begin
            if (i % 10 == 9)
                offer(CMD_POLL, SAMPLE_BITS'($urandom), MODE_CONTINUOUS);
            else
                offer(CMD_SAMPLE, SAMPLE_BITS'($urandom), MODE_W'($urandom));
        end

        // sender heavy, receiver light
        send_gap_pct = 60;
        take_gap_pct = 14;
        apply_settings(cfg_t'{7'd0, 7'd0, 7'd0, 16'd0, 16'd0, 16'd0, 8'd0});
        for (int i = 0; i < 120; i++)
        begin
            if (i == 60)
                quiesce();
            offer_random();
        end
        apply_settings(cfg_t'{7'd10, 7'd40, 7'd20, 16'd5, 16'd12, 16'd3, 8'd2});
        repeat (100) offer_random();

        // no idling; receiver chokes while polls keep coming
        send_gap_pct = 0;
        take_gap_pct = 0;
        apply_settings(cfg_t'{7'd3, 7'd8, 7'd12, 16'd1, 16'd1, 16'd1, 8'd1});
        choke_go <= 1'b1;
        offer(CMD_SAMPLE, 12'hFFF, MODE_CONTINUOUS);
        offer(CMD_SAMPLE, 12'hFFF, MODE_CONTINUOUS);
        repeat (24) offer(CMD_POLL, SAMPLE_BITS'($urandom), MODE_CONTINUOUS);
        repeat (120) offer_random();

        quiesce();
        $display("run summary: %0d input words under %0d register settings, %0d results compared",
                 words_sent, settings_used, compared);
        $display("run summary: all poll modes, ignored commands, saturation, count wrap, %s",
                 "a long output stall and a full drain");
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
